// ----- hdl/bce_pkg.sv -----
// ----------------------------------------------------------------------------
// bce_pkg
// Types, constants and the percent breakpoint table of the battery estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

	localparam int unsigned TABLE_POINTS = 22;
	localparam int unsigned IDX_W        = $clog2(TABLE_POINTS);

	localparam int unsigned MV_W    = 14;
	localparam int unsigned ADC_W   = 12;
	localparam int unsigned REG_W   = 10;
	localparam int unsigned SUM_W   = 18;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned BAR_W   = 3;

	localparam int unsigned MUL_W   = 57;
	localparam int unsigned DIVN_W  = 34;
	localparam int unsigned DIVD_W  = 20;
	localparam int unsigned STEP_W  = 6;

	localparam logic [1:0] REG_R1    = 2'd0;
	localparam logic [1:0] REG_R2    = 2'd1;
	localparam logic [1:0] REG_DELTA = 2'd2;

	// m*1000*2^24 + 0.0028*m*m*2^24 + 0.0096*m*1000*2^24 = m*(K_LIN + K_SQ*m)
	localparam logic [33:0] K_LIN  = 34'd16938277000;
	localparam logic [15:0] K_SQ   = 16'd46976;
	localparam logic [45:0] K_OFS  = 46'd855638016000;

	localparam logic [MV_W-1:0]  MV_MAX    = 14'd16383;
	localparam logic [SUM_W-1:0] SUM_MAX   = 18'd262143;
	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
	localparam logic [MV_W-1:0]  LOW_MV    = 14'd2800;

	localparam logic [MV_W-1:0] PCT_ROM [TABLE_POINTS] = '{
		14'd2600, 14'd3100, 14'd3200, 14'd3260, 14'd3290, 14'd3330, 14'd3370, 14'd3410,
		14'd3460, 14'd3510, 14'd3560, 14'd3610, 14'd3650, 14'd3690, 14'd3720, 14'd3750,
		14'd3780, 14'd3820, 14'd3880, 14'd3950, 14'd4030, 14'd4250
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_A,
		ST_SIGN,
		ST_MUL_B,
		ST_DIV_LD,
		ST_DIV_SCALE,
		ST_POST,
		ST_DIV_AVG,
		ST_CHG,
		ST_SRCH,
		ST_DIV_PCT,
		ST_FIN
	} state_t;

	function automatic logic [BAR_W-1:0] bars_of(input logic [MV_W-1:0] v);
		logic [BAR_W-1:0] b;
		if (v >= 14'd3820)      b = 3'd6;
		else if (v >= 14'd3720) b = 3'd5;
		else if (v >= 14'd3610) b = 3'd4;
		else if (v >= 14'd3460) b = 3'd3;
		else if (v >= 14'd3330) b = 3'd2;
		else if (v >= 14'd3200) b = 3'd1;
		else                    b = 3'd0;
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/battery_charge_estimator.sv -----
// ----------------------------------------------------------------------------
// battery_charge_estimator
// Battery voltage, state of charge, bar count and charger detection.
// ----------------------------------------------------------------------------
// One word in gives one word out. A shared shift-add multiplier forms both
// products of the voltage scaling. A shared restoring divider takes one
// quotient bit per cycle: 34 bits for the voltage scaling, 19 for the minute
// average when tlast closes a minute and 18 for the percent fraction. The
// breakpoint search visits one entry per cycle. A finished word waits in the
// output register while the next word is taken.
`default_nettype none

module battery_charge_estimator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [bce_pkg::REG_W-1:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // adc_mv [11:0]
	input  wire logic        s_tlast,   // minute_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // battery_mv, charge_percent, bar_level,
	                                    // low_battery, charging
);
	import bce_pkg::*;

	state_t state_q, state_d;

	logic [REG_W-1:0]        r1_q, r2_q;
	logic signed [REG_W-1:0] delta_q;

	logic [ADC_W-1:0] m_q;
	logic             mend_q;
	logic             neg_q;

	logic [MUL_W-1:0]  mul_a_q, acc_q;
	logic [ADC_W-1:0]  mul_b_q;
	logic [DIVN_W-1:0] div_num_q, div_quo_q;
	logic [DIVD_W-1:0] div_den_q, div_rem_q;
	logic [STEP_W-1:0] cnt_q;

	logic [MV_W-1:0]  h1_q, h2_q, h3_q, prev_q, v_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic             chg_q;
	logic [IDX_W-1:0] idx_q;
	logic [PCT_W-1:0] pct_q;

	logic             out_valid_q;
	logic [31:0]      out_data_q;

	logic [REG_W-1:0]   r2e;
	logic [REG_W:0]     ratio_sum;
	logic [33:0]        t_val;
	logic [DIVD_W:0]    trial;
	logic               trial_ge;
	logic signed [35:0] q_s, sv;
	logic [MV_W-1:0]    v_scaled, v_smooth;
	logic [15:0]        sum4;
	logic [SUM_W:0]     sum_add;
	logic [SUM_W-1:0]   sum_new;
	logic [CNT_W-1:0]   count_new, n_div;
	logic [SUM_W:0]     avg_num;
	logic [MV_W-1:0]    avg;
	logic [MV_W-1:0]    lo, hi, span;
	logic [IDX_W-1:0]   idx_nx;
	logic [17:0]        frac_num;
	logic [7:0]         pct_sum;
	logic               pct_interp;
	logic [PCT_W-1:0]   pct_out;
	logic               div_last, out_free;

	assign r2e       = (r2_q == '0) ? REG_W'(1) : r2_q;
	assign ratio_sum = {1'b0, r1_q} + {1'b0, r2e};
	assign t_val     = K_LIN + 34'(m_q) * 34'(K_SQ);

	assign trial    = {div_rem_q, div_num_q[DIVN_W-1]};
	assign trial_ge = trial >= {1'b0, div_den_q};
	assign div_last = cnt_q == STEP_W'(1);

	assign q_s      = neg_q ? -$signed({2'b00, div_quo_q}) : $signed({2'b00, div_quo_q});
	assign sv       = q_s + 36'(delta_q);
	assign v_scaled = sv[35] ? '0 : ((sv > 36'sd16383) ? MV_MAX : sv[MV_W-1:0]);
	assign sum4     = 16'(v_scaled) + 16'(h1_q) + 16'(h2_q) + 16'(h3_q) + 16'd2;
	assign v_smooth = (h3_q != '0) ? sum4[15:2] : v_scaled;
	assign sum_add  = {1'b0, sum_q} + (SUM_W+1)'(v_smooth);
	assign sum_new  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
	assign count_new = (count_q < COUNT_MAX) ? count_q + CNT_W'(1) : count_q;
	assign n_div    = (count_new > CNT_W'(1)) ? count_new - CNT_W'(1) : CNT_W'(1);
	assign avg_num  = (SUM_W+1)'(sum_new) + (SUM_W+1)'(n_div[CNT_W-1:1]);
	assign avg      = (div_quo_q[SUM_W:0] > (SUM_W+1)'(MV_MAX)) ? MV_MAX
	                                                            : div_quo_q[MV_W-1:0];

	assign idx_nx   = idx_q + IDX_W'(1);
	assign lo       = PCT_ROM[idx_q];
	assign hi       = PCT_ROM[idx_nx];
	assign span     = hi - lo;
	assign frac_num = 18'(v_q - lo) * 18'd10 + 18'(span);
	assign pct_sum  = 8'(idx_q) * 8'd5 + div_quo_q[7:0];

	assign pct_interp = (v_q >= PCT_ROM[0]) && (v_q < hi) && (hi > lo);
	assign pct_out    = !pct_interp ? pct_q
	                    : ((pct_sum > 8'd100) ? PCT_W'(100) : pct_sum[PCT_W-1:0]);

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_PREP;
			ST_PREP:      state_d = ST_MUL_A;
			ST_MUL_A:     if (div_last) state_d = ST_SIGN;
			ST_SIGN:      state_d = ST_MUL_B;
			ST_MUL_B:     if (div_last) state_d = ST_DIV_LD;
			ST_DIV_LD:    state_d = ST_DIV_SCALE;
			ST_DIV_SCALE: if (div_last) state_d = ST_POST;
			ST_POST:      state_d = mend_q ? ST_DIV_AVG : ST_SRCH;
			ST_DIV_AVG:   if (div_last) state_d = ST_CHG;
			ST_CHG:       state_d = ST_SRCH;
			ST_SRCH: begin
				if (v_q < PCT_ROM[0]) state_d = ST_FIN;
				else if (v_q < hi && hi > lo) state_d = ST_DIV_PCT;
				else if (idx_nx == IDX_W'(TABLE_POINTS - 1)) state_d = ST_FIN;
			end
			ST_DIV_PCT:   if (div_last) state_d = ST_FIN;
			ST_FIN:       if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = state_q == ST_IDLE;
		m_tvalid = out_valid_q;
		m_tdata  = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r1_q        <= REG_W'(50);
			r2_q        <= REG_W'(100);
			delta_q     <= '0;
			h1_q        <= '0;
			h2_q        <= '0;
			h3_q        <= '0;
			sum_q       <= '0;
			count_q     <= CNT_W'(1);
			prev_q      <= '0;
			chg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_R1:    r1_q <= cfg_data;
					REG_R2:    r2_q <= cfg_data;
					REG_DELTA: delta_q <= $signed(cfg_data);
					default:   ;
				endcase
			end
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_POST: begin
					h1_q    <= v_smooth;
					h2_q    <= h1_q;
					h3_q    <= h2_q;
					sum_q   <= sum_new;
					count_q <= count_new;
				end
				ST_CHG: begin
					chg_q   <= (prev_q != '0) && (15'(avg) > 15'(prev_q) + 15'd1);
					prev_q  <= avg;
					sum_q   <= '0;
					count_q <= CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				m_q    <= s_tdata[ADC_W-1:0];
				mend_q <= s_tlast;
			end
			ST_PREP: begin
				mul_a_q <= MUL_W'(t_val);
				mul_b_q <= m_q;
				acc_q   <= '0;
				cnt_q   <= STEP_W'(ADC_W);
			end
			ST_MUL_A, ST_MUL_B: begin
				if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
				cnt_q   <= cnt_q - STEP_W'(1);
			end
			ST_SIGN: begin
				neg_q   <= acc_q[45:0] < K_OFS;
				mul_a_q <= (acc_q[45:0] < K_OFS) ? MUL_W'(K_OFS - acc_q[45:0])
				                                : MUL_W'(acc_q[45:0] - K_OFS);
				mul_b_q <= ADC_W'(ratio_sum);
				acc_q   <= '0;
				cnt_q   <= STEP_W'(REG_W + 1);
			end
			ST_DIV_LD: begin
				div_num_q <= DIVN_W'(acc_q[MUL_W-1:24]) + DIVN_W'(r2e) * DIVN_W'(10'd500);
				div_den_q <= DIVD_W'(r2e) * DIVD_W'(10'd1000);
				div_rem_q <= '0;
				cnt_q     <= STEP_W'(DIVN_W);
			end
			ST_DIV_SCALE, ST_DIV_AVG, ST_DIV_PCT: begin
				div_rem_q <= trial_ge ? DIVD_W'(trial - {1'b0, div_den_q})
				                      : trial[DIVD_W-1:0];
				div_quo_q <= {div_quo_q[DIVN_W-2:0], trial_ge};
				div_num_q <= div_num_q << 1;
				cnt_q     <= cnt_q - STEP_W'(1);
			end
			ST_POST: begin
				v_q       <= v_smooth;
				idx_q     <= '0;
				div_num_q <= {avg_num, 15'd0};
				div_den_q <= DIVD_W'(n_div);
				div_rem_q <= '0;
				cnt_q     <= STEP_W'(SUM_W + 1);
			end
			ST_SRCH: begin
				if (v_q < PCT_ROM[0]) begin
					pct_q <= '0;
				end else if (v_q < hi && hi > lo) begin
					div_num_q <= {frac_num, 16'd0};
					div_den_q <= DIVD_W'({span, 1'b0});
					div_rem_q <= '0;
					cnt_q     <= STEP_W'(18);
				end else if (idx_nx == IDX_W'(TABLE_POINTS - 1)) begin
					pct_q <= PCT_W'(100);
				end else begin
					idx_q <= idx_nx;
				end
			end
			default: ;
		endcase
		if (state_q == ST_FIN && out_free) begin
			out_data_q <= {6'd0, chg_q, v_q < LOW_MV, bars_of(v_q), pct_out, v_q};
		end
	end

endmodule

`default_nettype wire

// ----- dv/battery_charge_estimator_test.sv -----
// ----------------------------------------------------------------------------
// battery_charge_estimator_test
// Drives ADC words with random gaps and register changes, predicts each
// battery voltage, percent, bar, low and charging word, and checks the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module battery_charge_estimator_test;

	import bce_pkg::*;

	typedef struct packed {
		logic [ADC_W-1:0] adc;
		logic             mend;
	} sample_t;

	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [PCT_W-1:0] pct;
		logic [BAR_W-1:0] bars;
		logic             low;
		logic             chg;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_R1;
	logic [REG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;

	sample_t  pending_samples[$];
	reading_t expected_readings[$];
	int  failures = 0;
	bit  calm = 1'b0;
	bit  sending = 1'b0;
	bit  in_taken = 1'b0;

	// Predictor state
	longint unsigned r1_val, r2_val;
	longint signed   delta_val;
	int unsigned h1, h2, h3, msum, scount, prev_avg;
	bit chg_flag;

	battery_charge_estimator u_dut (.*);

	always #5 clk = ~clk;

	function automatic int unsigned scale_mv(int unsigned m);
		longint signed mm, r2, num, den, mag, q, v;
		mm = m;
		r2 = (r2_val != 0) ? longint'(r2_val) : 1;
		num = mm * 1000 * 16777216 + 46976 * mm * mm + 161061 * mm * 1000
			- longint'(51000) * 16777216;
		den = r2 * 1000 * 16777216;
		num = num * (longint'(r1_val) + r2);
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		if (num < 0) q = -q;
		v = q + delta_val;
		if (v < 0) v = 0;
		if (v > 16383) v = 16383;
		return int'(v);
	endfunction

	function automatic int unsigned percent_of_mv(int unsigned v);
		int unsigned lo, hi, span, p;
		if (v < PCT_ROM[0]) return 0;
		for (int i = 0; i + 1 < TABLE_POINTS; i++) begin
			lo = PCT_ROM[i];
			hi = PCT_ROM[i + 1];
			if (v < hi && hi > lo) begin
				span = hi - lo;
				p = i * 5 + ((v - lo) * 10 + span) / (2 * span);
				return (p > 100) ? 100 : p;
			end
		end
		return 100;
	endfunction

	function automatic int unsigned bar_count(int unsigned v);
		if (v >= 3820) return 6;
		if (v >= 3720) return 5;
		if (v >= 3610) return 4;
		if (v >= 3460) return 3;
		if (v >= 3330) return 2;
		if (v >= 3200) return 1;
		return 0;
	endfunction

	function automatic reading_t estimate_reading(sample_t s);
		reading_t r;
		int unsigned v, n, avg;
		v = scale_mv(s.adc);
		if (h3 > 0) v = (v + h1 + h2 + h3 + 2) >> 2;
		msum += v;
		if (msum > 262143) msum = 262143;
		h3 = h2;
		h2 = h1;
		h1 = v;
		if (scount < 31) scount++;
		if (s.mend) begin
			n = (scount > 1) ? scount - 1 : 1;
			avg = (msum + n / 2) / n;
			if (avg > 16383) avg = 16383;
			chg_flag = (prev_avg > 0) && (avg > prev_avg + 1);
			prev_avg = avg;
			msum = 0;
			scount = 1;
		end
		r.mv = MV_W'(v);
		r.pct = PCT_W'(percent_of_mv(v));
		r.bars = BAR_W'(bar_count(v));
		r.low = (v < 2800);
		r.chg = chg_flag;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_readings.push_back(estimate_reading({s_tdata[ADC_W-1:0], s_tlast}));
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				in_taken = 1'b0;
				if (sending && pending_samples.size() > 0
					&& (calm || $urandom_range(99) >= 35)) begin
					sample_t s;
					s = pending_samples.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'd0, s.adc};
					s_tlast <= s.mend;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= calm || ($urandom_range(99) >= 35);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			reading_t e, a;
			a = m_tdata[MV_W+PCT_W+BAR_W+1:0] ;
			a.mv = m_tdata[13:0];
			a.pct = m_tdata[20:14];
			a.bars = m_tdata[23:21];
			a.low = m_tdata[24];
			a.chg = m_tdata[25];
			if (expected_readings.size() == 0) begin
				$error("unexpected word %h", m_tdata);
				failures++;
			end else begin
				e = expected_readings.pop_front();
				if (a.mv !== e.mv) begin
					$error("battery_mv expected %0d actual %0d", e.mv, a.mv);
					failures++;
				end
				if (a.pct !== e.pct) begin
					$error("charge_percent expected %0d actual %0d", e.pct, a.pct);
					failures++;
				end
				if (a.bars !== e.bars) begin
					$error("bar_level expected %0d actual %0d", e.bars, a.bars);
					failures++;
				end
				if (a.low !== e.low) begin
					$error("low_battery expected %0d actual %0d", e.low, a.low);
					failures++;
				end
				if (a.chg !== e.chg) begin
					$error("charging expected %0d actual %0d", e.chg, a.chg);
					failures++;
				end
			end
		end
	end

	task automatic drain();
		wait (pending_samples.size() == 0);
		sending = 1'b0;
		while (s_tvalid || expected_readings.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_R1) r1_val = val;
		else if (idx == REG_R2) r2_val = val;
		else if (idx == REG_DELTA) delta_val = $signed(val);
	endtask

	task automatic add_sample(int unsigned adc, bit mend);
		sample_t s;
		s.adc = ADC_W'(adc);
		s.mend = mend;
		pending_samples.push_back(s);
	endtask

	// A minute is a run of samples near one level, drifting up or down.
	task automatic add_minutes(int count);
		int unsigned base, len;
		int drift;
		for (int k = 0; k < count; k++) begin
			base = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(3600);
			drift = $urandom_range(40) - 20;
			len = ($urandom_range(15) == 0) ? $urandom_range(40, 32) : $urandom_range(12, 1);
			for (int j = 0; j < len; j++) begin
				int v;
				v = int'(base) + drift * j + int'($urandom_range(8)) - 4;
				if (v < 0) v = 0;
				if (v > 4095) v = 4095;
				add_sample(v, j == len - 1);
			end
		end
	endtask

	initial begin
		r1_val = 50;
		r2_val = 100;
		delta_val = 0;
		h1 = 0; h2 = 0; h3 = 0;
		msum = 0; scount = 1; prev_avg = 0; chg_flag = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_sample(0, 0);
		add_sample(4095, 0);
		add_sample(3600, 1);
		add_sample(2000, 1);
		add_sample(2600, 0);
		add_sample(2700, 1);
		add_sample(2800, 1);
		add_sample(2900, 0);
		add_sample(2345, 1);
		add_sample(1365, 0);
		add_sample(2730, 1);
		sending = 1'b1;
		drain();

		write_reg(REG_R2, 0);
		write_reg(REG_R1, 0);
		write_reg(REG_DELTA, 10'h3FF);
		add_sample(50, 1);
		add_sample(4095, 0);
		add_sample(3000, 1);
		sending = 1'b1;
		drain();
		write_reg(2'd3, 10'h155);
		write_reg(REG_R1, 1023);
		write_reg(REG_R2, 1);
		write_reg(REG_DELTA, 10'h200);
		add_sample(4095, 0);
		add_sample(0, 1);
		for (int i = 0; i < 40; i++) add_sample(4095, i == 39);
		sending = 1'b1;
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			write_reg(REG_R1, (phase == 1) ? REG_W'(1000) : REG_W'($urandom_range(300, 1)));
			write_reg(REG_R2, (phase == 2) ? REG_W'(1) : REG_W'($urandom_range(1000, 200)));
			write_reg(REG_DELTA, (phase == 3) ? 10'h1F4 : (phase == 4) ? 10'h20C
				: REG_W'($urandom_range(1023)));
			calm = (phase == 2);
			add_minutes(32);
			sending = 1'b1;
			drain();
		end

		if (failures == 0) begin
			$display("PASS battery_charge_estimator");
		end else begin
			$display("FAIL battery_charge_estimator");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("FAIL battery_charge_estimator");
		$finish;
	end

endmodule
